// ===== hdl/lpc_pkg.sv =====
// Shared widths, types and a helper function for the line position centroid unit.
package lpc_pkg;

    // Fixed field widths
    localparam int FIELD_W     = 10;   // one reflectance sample
    localparam int MAX_SENSORS = 8;
    localparam int MASK_W      = MAX_SENSORS;
    localparam int POS_W       = 13;   // position and center
    localparam int ERR_W       = POS_W + 1;
    localparam int POS_STEP    = 1000; // position units between neighboring sensors

    // Datapath widths
    localparam int SEL_W  = $clog2(MAX_SENSORS);
    localparam int IDX_W  = $clog2(MAX_SENSORS + 1);
    localparam int WGT_W  = POS_W;                                  // up to 7000
    localparam int PROD_W = FIELD_W + WGT_W;                        // sample times weight
    localparam int SUM_W  = PROD_W + SEL_W - 1;                     // sum of up to eight products
    localparam int TOT_W  = FIELD_W + SEL_W;                        // sum of up to eight samples
    localparam int CNT_W  = $clog2(POS_W + 1);                      // divider step counter

    typedef logic [MAX_SENSORS-1:0][FIELD_W-1:0] t_frame;

    // Result of one accumulation pass
    typedef struct packed {
        logic              done;
        logic [MASK_W-1:0] mask;
        logic [SUM_W-1:0]  sum;
        logic [TOT_W-1:0]  total;
    } t_acc_res;

    // Position weight of sensor idx
    function automatic logic [WGT_W-1:0] pos_weight(input logic [SEL_W-1:0] idx);
        logic [WGT_W-1:0] w;
        w = WGT_W'(idx) * WGT_W'(POS_STEP);
        return w;
    endfunction

endpackage

// ===== hdl/lpc_accum.sv =====
// Sequential scan of the sensors: threshold compare, weighting and accumulation.
module lpc_accum #(
    parameter int SENSOR_COUNT = 8,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  lpc_pkg::t_frame               i_frame,
    input  logic [lpc_pkg::FIELD_W-1:0]   i_threshold,
    output lpc_pkg::t_acc_res             o_res
);

    localparam int SW = (SAMPLE_BITS < lpc_pkg::FIELD_W) ? SAMPLE_BITS : lpc_pkg::FIELD_W;
    localparam logic [lpc_pkg::FIELD_W-1:0] SMASK = lpc_pkg::FIELD_W'((1 << SW) - 1);
    localparam logic [lpc_pkg::IDX_W-1:0]   LAST  = lpc_pkg::IDX_W'(SENSOR_COUNT);

    logic                          r_busy;
    logic                          r_done;
    logic [lpc_pkg::IDX_W-1:0]     r_idx;
    logic [lpc_pkg::PROD_W-1:0]    r_prod;
    logic [lpc_pkg::FIELD_W-1:0]   r_padd;
    logic [lpc_pkg::SUM_W-1:0]     r_sum;
    logic [lpc_pkg::TOT_W-1:0]     r_total;
    logic [lpc_pkg::MASK_W-1:0]    r_mask;

    logic [lpc_pkg::SEL_W-1:0]     sel;
    logic [lpc_pkg::FIELD_W-1:0]   samp;
    logic                          det;

    // Current sensor sample and its threshold compare
    assign sel  = r_idx[lpc_pkg::SEL_W-1:0];
    assign samp = i_frame[sel] & SMASK;
    assign det  = samp > i_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_idx == LAST)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Weight one sensor per cycle; add the previous product in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx   <= '0;
            r_prod  <= '0;
            r_padd  <= '0;
            r_sum   <= '0;
            r_total <= '0;
            r_mask  <= '0;
        end else if (r_busy) begin
            r_sum   <= r_sum + lpc_pkg::SUM_W'(r_prod);
            r_total <= r_total + lpc_pkg::TOT_W'(r_padd);
            if (r_idx != LAST) begin
                r_idx       <= r_idx + 1'b1;
                r_mask[sel] <= det;
                r_prod      <= det ? lpc_pkg::PROD_W'(samp) *
                                     lpc_pkg::PROD_W'(lpc_pkg::pos_weight(sel)) : '0;
                r_padd      <= det ? samp : '0;
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.mask  = r_mask;
    assign o_res.sum   = r_sum;
    assign o_res.total = r_total;

endmodule

// ===== hdl/lpc_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module lpc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lpc_pkg::SUM_W-1:0]     i_dividend,
    input  logic [lpc_pkg::TOT_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [lpc_pkg::POS_W-1:0]     o_quotient
);

    localparam int REM_W = lpc_pkg::TOT_W + 1;

    logic                          r_busy;
    logic                          r_done;
    logic [lpc_pkg::CNT_W-1:0]     r_cnt;
    logic [REM_W-1:0]              r_rem;
    logic [lpc_pkg::POS_W-1:0]     r_dq;   // dividend low bits in, quotient bits out
    logic [lpc_pkg::TOT_W-1:0]     r_div;

    logic [REM_W-1:0]              trial;
    logic                          fits;

    // Quotient is below 2**POS_W, so the upper dividend bits start as the remainder
    assign trial = {r_rem[REM_W-2:0], r_dq[lpc_pkg::POS_W-1]};
    assign fits  = trial >= REM_W'(r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == lpc_pkg::CNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Shift, trial subtract, restore
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= lpc_pkg::CNT_W'(lpc_pkg::POS_W);
            r_rem <= REM_W'(i_dividend[lpc_pkg::SUM_W-1:lpc_pkg::POS_W]);
            r_dq  <= i_dividend[lpc_pkg::POS_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= fits ? (trial - REM_W'(r_div)) : trial;
            r_dq  <= {r_dq[lpc_pkg::POS_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

// ===== hdl/line_position_centroid_unit.sv =====
// Top level of the line position centroid unit: sequencer, registers and output stage.
//
// One frame of sensor samples is taken at a time. A frame with a detected line passes
// through the single multiply-accumulate scan over the sensors, the serial divider
// (one quotient bit per cycle) and the sequencing states. A frame with no detected
// sensor skips the divider. The input stalls while a frame is in work, so a new frame
// is taken only once the previous one is finished. The finished result sits in an
// output register, so the next frame is taken while the previous result still waits.
// Register writes are taken at any time but must only be made while the unit is
// idle.
module line_position_centroid_unit #(
    parameter int SENSOR_COUNT = 8,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [lpc_pkg::POS_W-1:0]         i_cfg_data,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lpc_pkg::FIELD_W-1:0]       i_sensor_0,
    input  logic [lpc_pkg::FIELD_W-1:0]       i_sensor_1,
    input  logic [lpc_pkg::FIELD_W-1:0]       i_sensor_2,
    input  logic [lpc_pkg::FIELD_W-1:0]       i_sensor_3,
    input  logic [lpc_pkg::FIELD_W-1:0]       i_sensor_4,
    input  logic [lpc_pkg::FIELD_W-1:0]       i_sensor_5,
    input  logic [lpc_pkg::FIELD_W-1:0]       i_sensor_6,
    input  logic [lpc_pkg::FIELD_W-1:0]       i_sensor_7,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lpc_pkg::MASK_W-1:0]        o_detected_mask,
    output logic                              o_line_found,
    output logic [lpc_pkg::POS_W-1:0]         o_position,
    output logic signed [lpc_pkg::ERR_W-1:0]  o_steer_error
);

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_CENTER    = 1'b1;
    localparam logic [lpc_pkg::FIELD_W-1:0] THR_RESET = lpc_pkg::FIELD_W'(500);
    localparam logic [lpc_pkg::POS_W-1:0]   CTR_RESET = lpc_pkg::POS_W'(3500);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_DONE
    } t_state;

    t_state                              r_state;
    logic [lpc_pkg::FIELD_W-1:0]         r_thr;
    logic [lpc_pkg::POS_W-1:0]           r_center;
    lpc_pkg::t_frame                     r_frame;
    logic                                r_acc_start;
    logic                                r_div_start;
    logic                                r_found;
    logic [lpc_pkg::POS_W-1:0]           r_held_pos;
    logic [lpc_pkg::ERR_W-1:0]           r_held_err;
    logic                                r_out_valid;
    logic [lpc_pkg::MASK_W-1:0]          r_out_mask;
    logic                                r_out_found;
    logic [lpc_pkg::POS_W-1:0]           r_out_pos;
    logic [lpc_pkg::ERR_W-1:0]           r_out_err;

    lpc_pkg::t_acc_res                   acc_res;
    logic                                div_done;
    logic [lpc_pkg::POS_W-1:0]           quotient;
    logic                                in_xfer;
    logic                                out_free;
    logic [lpc_pkg::ERR_W-1:0]           new_err;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign new_err  = lpc_pkg::ERR_W'(quotient) - lpc_pkg::ERR_W'(r_center);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= THR_RESET;
            r_center <= CTR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THRESHOLD: r_thr    <= i_cfg_data[lpc_pkg::FIELD_W-1:0];
                REG_CENTER:    r_center <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Capture the frame on transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_frame[0] <= i_sensor_0;
            r_frame[1] <= i_sensor_1;
            r_frame[2] <= i_sensor_2;
            r_frame[3] <= i_sensor_3;
            r_frame[4] <= i_sensor_4;
            r_frame[5] <= i_sensor_5;
            r_frame[6] <= i_sensor_6;
            r_frame[7] <= i_sensor_7;
        end
    end

    lpc_accum #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_acc_start),
        .i_frame     (r_frame),
        .i_threshold (r_thr),
        .o_res       (acc_res)
    );

    lpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (acc_res.sum),
        .i_divisor  (acc_res.total),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Sequencer, held values and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_start <= 1'b0;
            r_div_start <= 1'b0;
            r_found     <= 1'b0;
            r_held_pos  <= '0;
            r_held_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc_start <= 1'b0;
            r_div_start <= 1'b0;
            // load a finished result or drop the one just taken
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_acc_start <= 1'b1;
                        r_state     <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (acc_res.done) begin
                        r_found <= (acc_res.mask != '0);
                        if (acc_res.mask != '0) begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_held_pos <= quotient;
                        r_held_err <= new_err;
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_found <= r_found;
                        r_out_mask  <= r_found ? acc_res.mask : '0;
                        r_out_pos   <= r_held_pos;
                        r_out_err   <= r_held_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_detected_mask = r_out_mask;
    assign o_line_found    = r_out_found;
    assign o_position      = r_out_pos;
    assign o_steer_error   = r_out_err;

endmodule

// ===== dv/line_position_centroid_unit_tb.sv =====
// Self-checking testbench for the line position centroid unit: directed table, then random frames.
module line_position_centroid_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Widths and types taken from the package
    localparam int FIELD_W     = lpc_pkg::FIELD_W;
    localparam int POS_W       = lpc_pkg::POS_W;
    localparam int ERR_W       = lpc_pkg::ERR_W;
    localparam int MASK_W      = lpc_pkg::MASK_W;
    localparam int MAX_SENSORS = lpc_pkg::MAX_SENSORS;
    localparam int POS_STEP    = lpc_pkg::POS_STEP;

    typedef lpc_pkg::t_frame t_frame;

    // Register indexes of the configuration port
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_CENTER    = 1'b1;

    localparam int SAMPLE_MAX     = (1 << FIELD_W) - 1;
    localparam int CENTER_MAX     = (1 << POS_W) - 1;
    localparam int RANDOM_FRAMES  = 1700;
    localparam int SETTLE_CYCLES  = 32;      // a little over the longest frame latency
    localparam int LIMIT_CYCLES   = 1000000;
    localparam int LONG_HOLD_AT   = 500;     // result count at which the sink holds off
    localparam int LONG_HOLD_LEN  = 800;

    typedef struct packed {
        logic [MASK_W-1:0]       mask;
        logic                    found;
        logic [POS_W-1:0]        pos;
        logic signed [ERR_W-1:0] err;
    } t_centroid;

    typedef struct packed {
        logic [FIELD_W-1:0] thr;
        logic [POS_W-1:0]   ctr;
        t_frame             frame;
        logic               typed;
        t_centroid          res;
    } t_stim_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic                    i_cfg_index;
    logic [POS_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [FIELD_W-1:0]      i_sensor_0, i_sensor_1, i_sensor_2, i_sensor_3;
    logic [FIELD_W-1:0]      i_sensor_4, i_sensor_5, i_sensor_6, i_sensor_7;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [MASK_W-1:0]       o_detected_mask;
    logic                    o_line_found;
    logic [POS_W-1:0]        o_position;
    logic signed [ERR_W-1:0] o_steer_error;

    // Shadow configuration and held centroid state
    logic [FIELD_W-1:0]      cur_threshold = 10'd500;
    logic [POS_W-1:0]        cur_center    = 13'd3500;
    logic [POS_W-1:0]        last_position = '0;
    logic signed [ERR_W-1:0] last_error    = '0;

    t_centroid pending_centroids[$];
    t_stim_row directed_rows[$];
    int        mismatches    = 0;
    int        results_seen  = 0;
    bit        tx_quiet      = 0;

    line_position_centroid_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sensor_0      (i_sensor_0),
        .i_sensor_1      (i_sensor_1),
        .i_sensor_2      (i_sensor_2),
        .i_sensor_3      (i_sensor_3),
        .i_sensor_4      (i_sensor_4),
        .i_sensor_5      (i_sensor_5),
        .i_sensor_6      (i_sensor_6),
        .i_sensor_7      (i_sensor_7),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_detected_mask (o_detected_mask),
        .o_line_found    (o_line_found),
        .o_position      (o_position),
        .o_steer_error   (o_steer_error)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("line_position_centroid_unit regression: fail");
        $finish;
    end

    // Print one error line and count it
    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Weighted centroid of one frame; updates the held position and error on a found line
    function automatic t_centroid centroid_of(input t_frame f);
        t_centroid   r;
        int unsigned wsum;
        int unsigned wtot;
        int          k;
        wsum   = 0;
        wtot   = 0;
        r.mask = '0;
        for (k = 0; k < MAX_SENSORS; k++) begin
            if (f[k] > cur_threshold) begin
                r.mask[k] = 1'b1;
                wsum += k * POS_STEP * int'(f[k]);
                wtot += int'(f[k]);
            end
        end
        r.found = (r.mask != '0);
        if (r.found) begin
            last_position = POS_W'(wsum / wtot);
            last_error    = ERR_W'(last_position) - ERR_W'(cur_center);
        end
        r.pos = last_position;
        r.err = last_error;
        return r;
    endfunction

    function automatic t_stim_row stim_row(input int thr, input int ctr,
                                           input t_frame f, input int typed,
                                           input logic [MASK_W-1:0] mask, input int found,
                                           input int pos, input int err);
        t_stim_row r;
        r.thr   = FIELD_W'(thr);
        r.ctr   = POS_W'(ctr);
        r.frame = f;
        r.typed = (typed != 0);
        r.res   = '{mask: mask, found: (found != 0), pos: POS_W'(pos), err: ERR_W'(err)};
        return r;
    endfunction

    // Offer one frame and hold it until the transfer; queue what it should produce
    task automatic push_frame(input t_frame f, input logic typed, input t_centroid typed_res);
        t_centroid predicted;
        i_in_valid <= 1'b1;
        i_sensor_0 <= f[0];
        i_sensor_1 <= f[1];
        i_sensor_2 <= f[2];
        i_sensor_3 <= f[3];
        i_sensor_4 <= f[4];
        i_sensor_5 <= f[5];
        i_sensor_6 <= f[6];
        i_sensor_7 <= f[7];
        do @(posedge i_clk); while (o_in_stall);
        predicted = centroid_of(f);
        pending_centroids.push_back(typed ? typed_res : predicted);
    endtask

    // Drop valid for a random gap: mostly none or short, a few long
    task automatic source_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (tx_quiet || pick < 55)
            n = 0;
        else if (pick < 85)
            n = $urandom_range(1, 3);
        else if (pick < 97)
            n = $urandom_range(4, 10);
        else
            n = $urandom_range(20, 60);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold the source until every queued result has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_centroids.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back; the unit must be idle
    task automatic write_config(input logic [POS_W-1:0] thr_data,
                                input logic [POS_W-1:0] ctr_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_THRESHOLD;
        i_cfg_data  <= thr_data;
        @(posedge i_clk);
        cur_threshold = thr_data[FIELD_W-1:0];
        i_cfg_index <= REG_CENTER;
        i_cfg_data  <= ctr_data;
        @(posedge i_clk);
        cur_center = ctr_data;
        i_cfg_we <= 1'b0;
    endtask

    // Random frame shaped around the current threshold
    function automatic t_frame random_frame();
        t_frame f;
        int     thr;
        int     kind;
        int     first;
        int     span;
        int     v;
        int     k;
        thr  = int'(cur_threshold);
        kind = $urandom_range(0, 9);
        f    = '0;
        case (kind)
            0, 1: begin
                for (k = 0; k < MAX_SENSORS; k++) f[k] = FIELD_W'($urandom_range(0, SAMPLE_MAX));
            end
            2, 3, 4, 5: begin
                // a line under one to three neighboring sensors over a dim floor
                first = $urandom_range(0, MAX_SENSORS - 1);
                span  = $urandom_range(1, 3);
                for (k = 0; k < MAX_SENSORS; k++) begin
                    if (k >= first && k < first + span)
                        f[k] = (thr < SAMPLE_MAX) ? FIELD_W'($urandom_range(thr + 1, SAMPLE_MAX))
                                                  : FIELD_W'(SAMPLE_MAX);
                    else
                        f[k] = FIELD_W'($urandom_range(0, thr));
                end
            end
            6: begin
                // samples right at the detection edge
                for (k = 0; k < MAX_SENSORS; k++) begin
                    v = thr + int'($urandom_range(0, 2)) - 1;
                    if (v < 0) v = 0;
                    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                    f[k] = FIELD_W'(v);
                end
            end
            7: begin
                for (k = 0; k < MAX_SENSORS; k++) f[k] = FIELD_W'($urandom_range(0, thr));
            end
            8: begin
                f[$urandom_range(0, MAX_SENSORS - 1)] = FIELD_W'($urandom_range(0, SAMPLE_MAX));
            end
            default: begin
                for (k = 0; k < MAX_SENSORS; k++) begin
                    case ($urandom_range(0, 4))
                        0:       f[k] = '0;
                        1:       f[k] = FIELD_W'(1);
                        2:       f[k] = FIELD_W'(SAMPLE_MAX - 1);
                        3:       f[k] = FIELD_W'(SAMPLE_MAX);
                        default: f[k] = cur_threshold;
                    endcase
                end
            end
        endcase
        return f;
    endfunction

    // Result sink: check each transfer, then pick the stall for the next cycle
    initial begin
        t_centroid want;
        int        stall_left;
        bit        held_off;
        bit        rx_quiet;
        int        pick;
        stall_left = 0;
        held_off   = 1'b0;
        rx_quiet   = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                results_seen++;
                if (pending_centroids.size() == 0) begin
                    log_error($sformatf("result %0d with nothing expected", results_seen));
                end else begin
                    want = pending_centroids.pop_front();
                    if (o_detected_mask !== want.mask)
                        log_error($sformatf("result %0d detected_mask: got %02h, want %02h",
                                            results_seen, o_detected_mask, want.mask));
                    if (o_line_found !== want.found)
                        log_error($sformatf("result %0d line_found: got %0b, want %0b",
                                            results_seen, o_line_found, want.found));
                    if (o_position !== want.pos)
                        log_error($sformatf("result %0d position: got %0d, want %0d",
                                            results_seen, o_position, want.pos));
                    if (o_steer_error !== want.err)
                        log_error($sformatf("result %0d steer_error: got %0d, want %0d",
                                            results_seen, o_steer_error, want.err));
                end
            end
            if ($urandom_range(0, 255) == 0) rx_quiet = ~rx_quiet;
            if (!held_off && results_seen >= LONG_HOLD_AT) begin
                // long hold-off so the unit backs up into its input
                held_off   = 1'b1;
                stall_left = LONG_HOLD_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (rx_quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    i_out_stall <= 1'b0;
                end else if (pick < 95) begin
                    stall_left = $urandom_range(0, 2);
                    i_out_stall <= 1'b1;
                end else begin
                    stall_left = $urandom_range(15, 50);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_stim_row        r;
        int               sent;
        int               phase_len;
        int               k;
        logic [FIELD_W-1:0] thr_pick;
        logic [POS_W-1:0] ctr_pick;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_THRESHOLD;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sensor_0  <= '0;
        i_sensor_1  <= '0;
        i_sensor_2  <= '0;
        i_sensor_3  <= '0;
        i_sensor_4  <= '0;
        i_sensor_5  <= '0;
        i_sensor_6  <= '0;
        i_sensor_7  <= '0;

        // Frames are written sensor 7 first. Reset settings: threshold 500, center 3500.
        // no line right after reset gives the cleared state
        directed_rows.push_back(stim_row(500, 3500, '0, 1, 8'h00, 0, 0, 0));
        directed_rows.push_back(stim_row(500, 3500, {8{10'd1023}}, 1, 8'hFF, 1, 3500, 0));
        directed_rows.push_back(stim_row(500, 3500, {10'd1023, 70'd0}, 1, 8'h80, 1, 7000, 3500));
        directed_rows.push_back(stim_row(500, 3500, {70'd0, 10'd1023}, 1, 8'h01, 1, 0, -14'sd3500));
        // sample equal to the threshold is not detected: held values again
        directed_rows.push_back(stim_row(500, 3500, {8{10'd500}}, 1, 8'h00, 0, 0, -14'sd3500));
        directed_rows.push_back(stim_row(500, 3500, {8{10'd501}}, 1, 8'hFF, 1, 3500, 0));
        directed_rows.push_back(stim_row(500, 3500, {4{10'h2AA, 10'h155}}, 0, '0, 0, 0, 0));
        directed_rows.push_back(stim_row(500, 3500, {4{10'h155, 10'h2AA}}, 0, '0, 0, 0, 0));
        // quotient that truncates
        directed_rows.push_back(stim_row(500, 3500, {50'd0, 10'd1022, 10'd1023, 10'd0},
                                         0, '0, 0, 0, 0));
        // lowest threshold: a sample of 1 is the smallest nonzero weight
        directed_rows.push_back(stim_row(0, 0, {70'd0, 10'd1}, 1, 8'h01, 1, 0, 0));
        directed_rows.push_back(stim_row(0, 0, {10'd1, 70'd0}, 1, 8'h80, 1, 7000, 7000));
        directed_rows.push_back(stim_row(0, 0, {8{10'd1}}, 1, 8'hFF, 1, 3500, 3500));
        directed_rows.push_back(stim_row(0, 0, '0, 1, 8'h00, 0, 3500, 3500));
        // top threshold: nothing can be detected
        directed_rows.push_back(stim_row(1023, 8191, {8{10'd1023}}, 1, 8'h00, 0, 3500, 3500));
        // largest center gives the most negative error
        directed_rows.push_back(stim_row(1022, 8191, {70'd0, 10'd1023}, 1, 8'h01, 1, 0,
                                         -14'sd8191));
        directed_rows.push_back(stim_row(1022, 8191, {10'd1023, 70'd0}, 1, 8'h80, 1, 7000,
                                         -14'sd1191));
        directed_rows.push_back(stim_row(1022, 7000, {10'd1023, 70'd0}, 1, 8'h80, 1, 7000, 0));
        directed_rows.push_back(stim_row(1022, 7000, {10'd0, 10'd1023, 40'd0, 10'd1023, 10'd0},
                                         1, 8'h42, 1, 3500, -14'sd3500));
        directed_rows.push_back(stim_row(511, 4096,
                                         {10'd0, 10'd512, 10'd300, 20'd0, 10'd700, 20'd0},
                                         0, '0, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            if (r.thr != cur_threshold || r.ctr != cur_center) begin
                wait_idle();
                write_config(POS_W'(r.thr), r.ctr);
            end
            push_frame(r.frame, r.typed, r.res);
            source_gap();
        end

        // Random phases, each under a fresh configuration
        sent = 0;
        while (sent < RANDOM_FRAMES) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       thr_pick = '0;
                1:       thr_pick = FIELD_W'(SAMPLE_MAX);
                2:       thr_pick = FIELD_W'(SAMPLE_MAX - 1);
                default: thr_pick = FIELD_W'($urandom_range(0, SAMPLE_MAX));
            endcase
            case ($urandom_range(0, 5))
                0:       ctr_pick = '0;
                1:       ctr_pick = 13'd7000;
                2:       ctr_pick = POS_W'(CENTER_MAX);
                3:       ctr_pick = 13'd3500;
                default: ctr_pick = POS_W'($urandom_range(0, CENTER_MAX));
            endcase
            // upper data bits above the threshold field are don't-care
            write_config({3'($urandom), thr_pick}, ctr_pick);
            tx_quiet  = ($urandom_range(0, 3) == 0);
            phase_len = (thr_pick == SAMPLE_MAX) ? 20 : $urandom_range(60, 200);
            for (k = 0; k < phase_len; k++) begin
                if (k == phase_len / 2 && $urandom_range(0, 3) == 0) wait_idle();
                push_frame(random_frame(), 1'b0, '0);
                sent++;
                source_gap();
            end
        end

        // Drain and let any stray result show up
        i_in_valid <= 1'b0;
        while (pending_centroids.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("line_position_centroid_unit regression: pass");
        else
            $display("line_position_centroid_unit regression: fail");
        $finish;
    end

endmodule
